// ===== hw/rtl/rf_pulse_width_capture_assert.svh =====
// Assertion macros for the pulse width capture RTL.
`ifndef RF_PULSE_WIDTH_CAPTURE_ASSERT_SVH
`define RF_PULSE_WIDTH_CAPTURE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising clock edge outside reset.
`define RFPWC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rfpwc assertion failed");
// Checked on every rising clock edge, reset included.
`define RFPWC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rfpwc assertion failed");
`else
`define RFPWC_ASSERT(lbl, prop)
`define RFPWC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hw/rtl/rfpwc_pkg.sv =====
// Package with widths, defaults and codes of the pulse width capture block.
package rfpwc_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int TIMER_BITS_DEF   = 24;

  localparam int SEG_W  = 7;
  localparam int DUR_W  = 24;
  localparam int RSSI_W = 8;
  localparam int CFG_W  = 23;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic [CFG_W-1:0] MIN_WIDTH_RST = CFG_W'(100);
  localparam logic [CFG_W-1:0] MAX_WIDTH_RST = CFG_W'(10000);

  typedef enum logic {
    REG_MIN_WIDTH = 1'b0,
    REG_MAX_WIDTH = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_GAP   = 2'd0,
    KIND_PULSE = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_FULL  = 2'd3
  } rec_kind_t;

endpackage

// ===== hw/rtl/rf_pulse_width_capture.sv =====
// Pulse and gap width capture for a sampled RF demodulator line.
// Each input item is one tick of the line; the block takes one item every clock cycle while
// not stalled. An accepted item waits in the input register and its result is then loaded into
// the result register. The input side stalls only while the result register holds an item
// that is not taken and the staged item yields another result. After the store-full record
// the block keeps accepting items and gives no further results.
`include "rf_pulse_width_capture_assert.svh"

module rf_pulse_width_capture #(
  parameter int MAX_SEGMENTS = rfpwc_pkg::MAX_SEGMENTS_DEF,
  parameter int TIMER_BITS   = rfpwc_pkg::TIMER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // line_level, rssi_dbm, zero pad
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,  // segment_index, duration, segment_rssi, pad
  output logic [1:0]                    out_tuser,  // record_kind
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rfpwc_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [rfpwc_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [rfpwc_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  localparam int SEG_W  = rfpwc_pkg::SEG_W;
  localparam int DUR_W  = rfpwc_pkg::DUR_W;
  localparam int RSSI_W = rfpwc_pkg::RSSI_W;
  localparam int CFG_W  = rfpwc_pkg::CFG_W;
  localparam int CMP_W  = (TIMER_BITS > CFG_W + 1) ? TIMER_BITS : CFG_W + 1;

  logic [CFG_W-1:0] min_width_r, max_width_r;

  logic                     s1_valid_r;
  logic                     s1_level_r;
  logic signed [RSSI_W-1:0] s1_rssi_r;

  logic                     prev_level_r, prev_level_nxt;
  logic [TIMER_BITS-1:0]    edge_timer_r, edge_timer_nxt, timer_inc;
  logic                     awaiting_r, awaiting_nxt;
  logic [SEG_W-1:0]         seg_r, seg_nxt;
  logic signed [RSSI_W-1:0] lat_rssi_r, lat_rssi_nxt;
  logic                     halted_r, halted_nxt;

  logic                     res_valid;
  rfpwc_pkg::rec_kind_t     res_kind;
  logic [DUR_W-1:0]         res_dur;
  logic signed [RSSI_W-1:0] res_rssi;

  logic                     out_valid_r;
  rfpwc_pkg::rec_kind_t     out_kind_r;
  logic [SEG_W-1:0]         out_seg_r;
  logic [DUR_W-1:0]         out_dur_r;
  logic signed [RSSI_W-1:0] out_rssi_r;

  logic s1_fire, cfg_wr, width_ok;
  logic [CMP_W-1:0] dur_ext;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_width_r <= rfpwc_pkg::MIN_WIDTH_RST;
      max_width_r <= rfpwc_pkg::MAX_WIDTH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        rfpwc_pkg::REG_MIN_WIDTH: min_width_r <= cfg_pwdata[CFG_W-1:0];
        rfpwc_pkg::REG_MAX_WIDTH: max_width_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      rfpwc_pkg::REG_MIN_WIDTH: cfg_prdata = rfpwc_pkg::APB_DW'(min_width_r);
      rfpwc_pkg::REG_MAX_WIDTH: cfg_prdata = rfpwc_pkg::APB_DW'(max_width_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // Input register.
  assign s1_fire   = s1_valid_r && (!res_valid || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_level_r <= in_tdata[0];
      s1_rssi_r  <= in_tdata[8:1];
    end
  end

  // Edge timing and segment tracking.
  assign timer_inc = (&edge_timer_r) ? edge_timer_r : edge_timer_r + TIMER_BITS'(1);
  assign dur_ext   = CMP_W'(edge_timer_r);
  assign width_ok  = (dur_ext > CMP_W'(min_width_r)) && (dur_ext < CMP_W'(max_width_r));

  always_comb begin
    prev_level_nxt = prev_level_r;
    edge_timer_nxt = edge_timer_r;
    awaiting_nxt   = awaiting_r;
    seg_nxt        = seg_r;
    lat_rssi_nxt   = lat_rssi_r;
    halted_nxt     = halted_r;
    res_valid      = 1'b0;
    res_kind       = rfpwc_pkg::KIND_GAP;
    res_dur        = '0;
    res_rssi       = lat_rssi_r;
    if (!s1_valid_r || halted_r) begin
      res_valid = 1'b0;
    end else if (seg_r >= SEG_W'(MAX_SEGMENTS)) begin
      res_valid  = 1'b1;
      res_kind   = rfpwc_pkg::KIND_FULL;
      res_rssi   = '0;
      halted_nxt = 1'b1;
    end else if (s1_level_r != prev_level_r) begin
      edge_timer_nxt = TIMER_BITS'(1);
      prev_level_nxt = s1_level_r;
      res_dur        = DUR_W'(edge_timer_r);
      if (width_ok) begin
        if (s1_level_r) begin
          if (awaiting_r) begin
            awaiting_nxt = 1'b0;
          end else begin
            res_valid = 1'b1;
            res_kind  = rfpwc_pkg::KIND_GAP;
          end
        end else begin
          if (lat_rssi_r == '0) begin
            lat_rssi_nxt = s1_rssi_r;
          end
          res_valid = 1'b1;
          res_kind  = rfpwc_pkg::KIND_PULSE;
          res_rssi  = lat_rssi_nxt;
        end
      end
    end else begin
      edge_timer_nxt = timer_inc;
      if (!s1_level_r && !awaiting_r &&
          (CMP_W'(timer_inc) > CMP_W'({max_width_r, 1'b0}))) begin
        res_valid    = 1'b1;
        res_kind     = rfpwc_pkg::KIND_CLOSE;
        seg_nxt      = seg_r + SEG_W'(1);
        awaiting_nxt = 1'b1;
        lat_rssi_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      edge_timer_r <= '0;
      awaiting_r   <= 1'b1;
      seg_r        <= '0;
      lat_rssi_r   <= '0;
      halted_r     <= 1'b0;
    end else if (s1_fire) begin
      prev_level_r <= prev_level_nxt;
      edge_timer_r <= edge_timer_nxt;
      awaiting_r   <= awaiting_nxt;
      seg_r        <= seg_nxt;
      lat_rssi_r   <= lat_rssi_nxt;
      halted_r     <= halted_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      out_kind_r <= res_kind;
      out_seg_r  <= seg_r;
      out_dur_r  <= res_dur;
      out_rssi_r <= res_rssi;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {1'b0, out_rssi_r, out_dur_r, out_seg_r};

  `RFPWC_ASSERT(a_halt_sticks, halted_r |=> halted_r)
  `RFPWC_ASSERT(a_full_only_halted, (out_tvalid && out_tuser == rfpwc_pkg::KIND_FULL) |-> halted_r)
  `RFPWC_ASSERT(a_seg_bounded, seg_r <= SEG_W'(MAX_SEGMENTS))
  `RFPWC_ASSERT(a_stage_holds, (s1_valid_r && !s1_fire) |=> (s1_valid_r && $stable(s1_level_r)))
  `RFPWC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_valid_r && !s1_valid_r))

endmodule

// ===== verif/rf_pulse_width_capture_test.sv =====
// Self-checking testbench for rf_pulse_width_capture: directed and random ticks vs a predictor.
module rf_pulse_width_capture_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEG_W    = rfpwc_pkg::SEG_W;
  localparam int DUR_W    = rfpwc_pkg::DUR_W;
  localparam int RSSI_W   = rfpwc_pkg::RSSI_W;
  localparam int CFG_W    = rfpwc_pkg::CFG_W;
  localparam int APB_AW   = rfpwc_pkg::APB_AW;
  localparam int APB_DW   = rfpwc_pkg::APB_DW;
  localparam int MAX_SEGS = rfpwc_pkg::MAX_SEGMENTS_DEF;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    rfpwc_pkg::rec_kind_t     kind;
    logic [SEG_W-1:0]         seg;
    logic [DUR_W-1:0]         dur;
    logic signed [RSSI_W-1:0] rssi;
  } capture_rec_t;

  typedef struct {
    logic                     lvl;
    logic signed [RSSI_W-1:0] rssi;
    bit                       given;
    bit                       has_rec;
    capture_rec_t             rec;
  } tick_row_t;

  localparam capture_rec_t NO_REC = '0;

  // Window of min 0 and max 3: widths 1 and 2 count, a low stretch of 7 closes.
  tick_row_t script [25] = '{
    '{1'b0, 8'sd0,   1'b1, 1'b0, NO_REC},
    '{1'b1, 8'sd0,   1'b0, 1'b0, NO_REC},
    '{1'b0, 8'sd0,   1'b1, 1'b1, '{rfpwc_pkg::KIND_PULSE, 7'd0, 24'd1, 8'sd0}},
    '{1'b1, 8'sd127, 1'b0, 1'b0, NO_REC},
    '{1'b1, 8'sd127, 1'b0, 1'b0, NO_REC},
    '{1'b0, 8'sd127, 1'b1, 1'b1, '{rfpwc_pkg::KIND_PULSE, 7'd0, 24'd2, 8'sd127}},
    '{1'b1, 8'sh80,  1'b0, 1'b0, NO_REC},
    '{1'b0, 8'sh80,  1'b1, 1'b1, '{rfpwc_pkg::KIND_PULSE, 7'd0, 24'd1, 8'sd127}},
    '{1'b0, 8'sd33,  1'b0, 1'b0, NO_REC},
    '{1'b0, 8'sd33,  1'b0, 1'b0, NO_REC},
    '{1'b1, 8'sd1,   1'b0, 1'b0, NO_REC},
    '{1'b1, 8'sd1,   1'b0, 1'b0, NO_REC},
    '{1'b1, 8'sd1,   1'b0, 1'b0, NO_REC},
    '{1'b0, 8'sd1,   1'b0, 1'b0, NO_REC},
    '{1'b0, 8'sd0,   1'b0, 1'b0, NO_REC},
    '{1'b0, 8'sd0,   1'b0, 1'b0, NO_REC},
    '{1'b0, 8'sd0,   1'b0, 1'b0, NO_REC},
    '{1'b0, 8'sd0,   1'b0, 1'b0, NO_REC},
    '{1'b0, 8'sd0,   1'b0, 1'b0, NO_REC},
    '{1'b0, 8'sd0,   1'b1, 1'b1, '{rfpwc_pkg::KIND_CLOSE, 7'd0, 24'd0, 8'sd127}},
    '{1'b0, 8'sd0,   1'b0, 1'b0, NO_REC},
    '{1'b1, 8'sd0,   1'b0, 1'b0, NO_REC},
    '{1'b0, 8'sh80,  1'b1, 1'b1, '{rfpwc_pkg::KIND_PULSE, 7'd1, 24'd1, 8'sh80}},
    '{1'b1, 8'sd5,   1'b0, 1'b0, NO_REC},
    '{1'b0, 8'sd0,   1'b0, 1'b0, NO_REC}
  };

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata    = '0;  // line_level, rssi_dbm, zero pad
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [39:0]       out_tdata;         // segment_index, duration, segment_rssi, pad
  logic [1:0]        out_tuser;         // record_kind
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [APB_AW-1:0] cfg_paddr   = '0;
  logic [APB_DW-1:0] cfg_pwdata  = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  rf_pulse_width_capture u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Predictor state and its copy of the width window.
  logic [CFG_W-1:0]         floor_ticks;
  logic [CFG_W-1:0]         ceil_ticks;
  logic                     prev_lvl;
  logic [DUR_W-1:0]         tick_count;
  bit                       wait_arm;
  logic [SEG_W-1:0]         seg_num;
  logic signed [RSSI_W-1:0] seg_rssi;
  bit                       stopped;

  capture_rec_t awaited_records [$];
  int  errors;
  int  ticks_sent;
  int  settings_used;
  int  kinds_seen [4];
  int  cycle_count;
  bit  tx_steady;
  bit  tx_push;
  bit  rx_steady;
  bit  hold_off_req;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rf_pulse_width_capture test failed");
      $finish;
    end
  end

  function automatic void queue_record(input capture_rec_t rec);
    awaited_records.insert(awaited_records.size(), rec);
  endfunction

  function automatic bit predict_tick(input logic lvl, input logic signed [RSSI_W-1:0] rssi,
                                      output capture_rec_t rec);
    logic [DUR_W-1:0] width;
    rec = '0;
    if (stopped) return 1'b0;
    if (seg_num >= MAX_SEGS) begin
      rec.kind = rfpwc_pkg::KIND_FULL;
      rec.seg  = seg_num;
      stopped  = 1'b1;
      return 1'b1;
    end
    if (lvl != prev_lvl) begin
      width      = tick_count;
      tick_count = DUR_W'(1);
      prev_lvl   = lvl;
      if (!(width > floor_ticks && width < ceil_ticks)) return 1'b0;
      if (lvl) begin
        if (wait_arm) begin
          wait_arm = 1'b0;
          return 1'b0;
        end
        rec = '{rfpwc_pkg::KIND_GAP, seg_num, width, seg_rssi};
        return 1'b1;
      end
      if (seg_rssi == 0) seg_rssi = rssi;
      rec = '{rfpwc_pkg::KIND_PULSE, seg_num, width, seg_rssi};
      return 1'b1;
    end
    if (tick_count != {DUR_W{1'b1}}) tick_count = tick_count + 1'b1;
    if (!lvl && !wait_arm && 32'(tick_count) > 32'(ceil_ticks) * 2) begin
      rec      = '{rfpwc_pkg::KIND_CLOSE, seg_num, '0, seg_rssi};
      seg_num  = seg_num + 1'b1;
      wait_arm = 1'b1;
      seg_rssi = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void track_tick(input logic lvl, input logic signed [RSSI_W-1:0] rssi);
    capture_rec_t rec;
    if (predict_tick(lvl, rssi, rec)) queue_record(rec);
  endfunction

  task automatic drive_tick(input logic lvl, input logic signed [RSSI_W-1:0] rssi);
    int gap;
    if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
    gap = (tx_steady || tx_push) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, rssi, lvl};
    do @(posedge clk); while (in_tready !== 1'b1);
    ticks_sent++;
  endtask

  task automatic feed_tick(input logic lvl);
    logic signed [RSSI_W-1:0] rssi;
    rssi = ($urandom_range(0, 4) == 0) ? 8'sd0 : RSSI_W'($urandom);
    drive_tick(lvl, rssi);
    track_tick(lvl, rssi);
  endtask

  task automatic send_pair(input int hi_len, input int lo_len);
    repeat (hi_len) feed_tick(1'b1);
    repeat (lo_len) feed_tick(1'b0);
  endtask

  // Width inside the window when asked and possible, else below it, above it or random.
  function automatic int pick_width(input bit good);
    int lo, hi, w;
    lo = int'(floor_ticks) + 1;
    hi = int'(ceil_ticks) - 1;
    if (good && lo <= hi) w = $urandom_range(lo, (hi < lo + 40) ? hi : lo + 40);
    else if ($urandom_range(0, 1) == 0 && floor_ticks >= 1)
      w = $urandom_range(1, (floor_ticks < 30) ? int'(floor_ticks) : 30);
    else if (ceil_ticks <= 60) w = int'(ceil_ticks) + $urandom_range(0, 3);
    else w = $urandom_range(1, 30);
    return (w < 1) ? 1 : w;
  endfunction

  function automatic int close_width();
    if (2 * int'(ceil_ticks) + 1 <= 120) return 2 * int'(ceil_ticks) + $urandom_range(1, 3);
    return $urandom_range(1, 40);
  endfunction

  // Mostly whole segments (arm, pulses and gaps, closing stretch), some random noise.
  // The run up to the full store uses short plain segments.
  task automatic random_traffic(input int n_ticks, input bit to_full);
    int start, k;
    start = ticks_sent;
    while (to_full ? !stopped : (ticks_sent - start < n_ticks)) begin
      if (!to_full && $urandom_range(0, 99) < 15) begin
        send_pair($urandom_range(1, 30), $urandom_range(1, 30));
      end else begin
        k = to_full ? 0 : $urandom_range(0, 2);
        send_pair(pick_width(1'b1), pick_width(1'b1));
        repeat (k) send_pair(pick_width($urandom_range(0, 4) != 0),
                             pick_width($urandom_range(0, 4) != 0));
        send_pair(pick_width(1'b1), close_width());
      end
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (awaited_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input rfpwc_pkg::reg_idx_t idx, input bit wr,
                            input logic [CFG_W-1:0] val, output logic [APB_DW-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= APB_AW'(int'(idx) * 4);
    cfg_pwdata  <= APB_DW'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input rfpwc_pkg::reg_idx_t idx, input logic [CFG_W-1:0] want);
    logic [APB_DW-1:0] rdata;
    apb_access(idx, 1'b0, '0, rdata);
    if (rdata !== APB_DW'(want)) begin
      $error("%s: expected %0d, got %0d", idx.name(), want, rdata);
      errors++;
    end
  endtask

  task automatic set_widths(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
    logic [APB_DW-1:0] rdata;
    apb_access(rfpwc_pkg::REG_MIN_WIDTH, 1'b1, lo, rdata);
    floor_ticks = lo;
    apb_access(rfpwc_pkg::REG_MAX_WIDTH, 1'b1, hi, rdata);
    ceil_ticks = hi;
    check_reg(rfpwc_pkg::REG_MIN_WIDTH, lo);
    check_reg(rfpwc_pkg::REG_MAX_WIDTH, hi);
    settings_used++;
  endtask

  initial begin : result_sink
    capture_rec_t got, want;
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
        stall = rx_steady ? 0 : $urandom_range(0, 19);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      got.kind = rfpwc_pkg::rec_kind_t'(out_tuser);
      got.seg  = out_tdata[6:0];
      got.dur  = out_tdata[30:7];
      got.rssi = out_tdata[38:31];
      kinds_seen[got.kind]++;
      if (awaited_records.size() == 0) begin
        $error("unexpected record: kind %0d, segment %0d", got.kind, got.seg);
        errors++;
      end else begin
        want = awaited_records.pop_front();
        if (got.kind !== want.kind) begin
          $error("record_kind: expected %0d, got %0d", want.kind, got.kind);
          errors++;
        end
        if (got.seg !== want.seg) begin
          $error("segment_index: expected %0d, got %0d", want.seg, got.seg);
          errors++;
        end
        if (got.dur !== want.dur) begin
          $error("duration: expected %0d, got %0d", want.dur, got.dur);
          errors++;
        end
        if (got.rssi !== want.rssi) begin
          $error("segment_rssi: expected %0d, got %0d", want.rssi, got.rssi);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    capture_rec_t scratch;
    floor_ticks = rfpwc_pkg::MIN_WIDTH_RST;
    ceil_ticks  = rfpwc_pkg::MAX_WIDTH_RST;
    prev_lvl    = 1'b0;
    tick_count  = '0;
    wait_arm    = 1'b1;
    seg_num     = '0;
    seg_rssi    = '0;
    stopped     = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_reg(rfpwc_pkg::REG_MIN_WIDTH, rfpwc_pkg::MIN_WIDTH_RST);
    check_reg(rfpwc_pkg::REG_MAX_WIDTH, rfpwc_pkg::MAX_WIDTH_RST);

    set_widths(23'd0, 23'd3);
    foreach (script[i]) begin
      drive_tick(script[i].lvl, script[i].rssi);
      if (script[i].given) begin
        void'(predict_tick(script[i].lvl, script[i].rssi, scratch));
        if (script[i].has_rec) queue_record(script[i].rec);
      end else begin
        track_tick(script[i].lvl, script[i].rssi);
      end
    end
    drain();

    set_widths(23'd2, 23'd10);
    random_traffic(60, 1'b0);
    drain();

    // The result side holds off while items keep coming back to back.
    set_widths(23'd5, 23'd30);
    tx_push = 1'b1;
    hold_off_req = 1'b1;
    random_traffic(100, 1'b0);
    tx_push = 1'b0;
    drain();

    set_widths({CFG_W{1'b1}}, {CFG_W{1'b1}});
    random_traffic(30, 1'b0);
    drain();

    set_widths(23'd0, 23'd0);
    random_traffic(30, 1'b0);
    drain();

    set_widths(23'd0, {CFG_W{1'b1}});
    random_traffic(60, 1'b0);
    drain();

    set_widths(23'd0, 23'd2);
    random_traffic(0, 1'b1);
    random_traffic(20, 1'b0);
    drain();

    $display("Covered %0d line ticks over %0d width windows, up to the full store and past it.",
             ticks_sent, settings_used);
    $display("Records checked: %0d gaps, %0d pulses, %0d closes, %0d store-full.",
             kinds_seen[rfpwc_pkg::KIND_GAP], kinds_seen[rfpwc_pkg::KIND_PULSE],
             kinds_seen[rfpwc_pkg::KIND_CLOSE], kinds_seen[rfpwc_pkg::KIND_FULL]);
    if (errors == 0) begin
      $display("rf_pulse_width_capture test passed");
    end else begin
      $display("rf_pulse_width_capture test failed");
    end
    $finish;
  end

endmodule
